@@ hdl/pfra_pkg.sv @@
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared widths, register indexes and opcodes of the packed field RMW ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package pfra_pkg;

    localparam int WORD_W  = 32;
    localparam int WIDX_W  = 4;
    localparam int CFG_W   = 3;
    localparam int OP_W    = 3;
    localparam int SIZE_W  = 2;
    localparam int MASK_W  = 16;
    localparam int LANES   = 4;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [WIDX_W-1:0] t_widx;
    typedef logic [CFG_W-1:0]  t_cfg_idx;

    // register indexes
    localparam t_cfg_idx CFG_OPCODE    = 3'd0;
    localparam t_cfg_idx CFG_OPERAND_A = 3'd1;
    localparam t_cfg_idx CFG_OPERAND_B = 3'd2;
    localparam t_cfg_idx CFG_FSIZE     = 3'd3;
    localparam t_cfg_idx CFG_MASK      = 3'd4;

    // opcodes
    localparam logic [OP_W-1:0] OP_INC_WRAP = 3'd0;
    localparam logic [OP_W-1:0] OP_INC      = 3'd1;
    localparam logic [OP_W-1:0] OP_SET      = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD      = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL      = 3'd4;

    // field size codes
    localparam logic [SIZE_W-1:0] FSIZE_B1 = 2'd0;
    localparam logic [SIZE_W-1:0] FSIZE_B2 = 2'd1;
    localparam logic [SIZE_W-1:0] FSIZE_B4 = 2'd2;

endpackage

`default_nettype wire

@@ hdl/pfra_req_if.sv @@
// ----------------------------------------------------------------------------
// pfra_req_if
// Input channel: one header word and its index per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfra_req_if;
    logic                    valid;
    logic                    ready;
    logic [pfra_pkg::WIDX_W-1:0] word_index;
    logic [pfra_pkg::WORD_W-1:0] word_value;

    modport source (output valid, output word_index, output word_value, input ready);
    modport sink   (input valid, input word_index, input word_value, output ready);
endinterface

`default_nettype wire

@@ hdl/pfra_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pfra_rsp_if
// Output channel: rewritten header word and write-back flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfra_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [pfra_pkg::WORD_W-1:0] new_word;
    logic                    word_written;

    modport source (output valid, output new_word, output word_written, input ready);
    modport sink   (input valid, input new_word, input word_written, output ready);
endinterface

`default_nettype wire

@@ hdl/packed_field_rmw_alu.sv @@
// ----------------------------------------------------------------------------
// packed_field_rmw_alu
// Read-modify-write of packed 1/2/4-byte fields in one 32-bit header word.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one header word and its word index per item; o_rsp returns
//   the word with every selected field rewritten, plus word_written when any
//   selected field lies inside that word. Exactly one result per item.
//   Configuration (opcode, operands, field size, update mask) is written on
//   the plain write port while no item is in flight.
// Timing:
//   The accepting edge loads the extraction stage (fields picked, old+a
//   formed), 32 stages of a restoring remainder unit follow (one quotient
//   bit per stage, four lanes, one per byte position), and the output
//   register then takes the selected ALU result with the fields merged in.
//   Throughput is one item per cycle while the output is not stalled, set by
//   the one-bit-per-stage remainder pipeline.
// Reset: clears all valid bits; configuration returns to its reset values
//   (opcode inc_wrap, operands zero, four-byte fields, empty mask).
// Stall: when the output register holds an unaccepted result the whole
//   pipeline freezes and i_req.ready drops; while the output register is
//   empty or being taken, items keep flowing, bubbles included.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_field_rmw_alu #(
    parameter int FIELD_COUNT = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    pfra_req_if.sink                     i_req,
    pfra_rsp_if.source                   o_rsp,
    input  wire                          i_cfg_we,
    input  wire [pfra_pkg::CFG_W-1:0]    i_cfg_idx,
    input  wire [pfra_pkg::WORD_W-1:0]   i_cfg_wdata
);
    import pfra_pkg::*;

    localparam int DIV_STG = WORD_W;
    localparam logic [MASK_W-1:0] FIELD_EN = MASK_W'((17'd1 << FIELD_COUNT) - 17'd1);

    // configuration registers
    logic [OP_W-1:0]   r_opcode;
    t_word             r_opa;
    t_word             r_opb;
    logic [SIZE_W-1:0] r_fsize;
    logic [MASK_W-1:0] r_mask;
    t_word             r_prod;
    t_word             r_apb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode <= OP_INC_WRAP;
            r_opa    <= '0;
            r_opb    <= '0;
            r_fsize  <= FSIZE_B4;
            r_mask   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OPCODE:    r_opcode <= i_cfg_wdata[OP_W-1:0];
                CFG_OPERAND_A: r_opa    <= i_cfg_wdata;
                CFG_OPERAND_B: r_opb    <= i_cfg_wdata;
                CFG_FSIZE:     r_fsize  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_MASK:      r_mask   <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // operand-only results, settled long before any item reaches the end
    always_ff @(posedge i_clk) begin
        r_prod <= r_opa * r_opb;
        r_apb  <= r_opa + r_opb;
    end

    // pipeline advance: move while the output register is free or taken
    logic w_adv;
    logic r_out_vld;
    assign w_adv       = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_adv;

    // field width mask
    t_word w_fmask;
    always_comb begin
        case (r_fsize)
            FSIZE_B1: w_fmask = 32'h0000_00FF;
            FSIZE_B2: w_fmask = 32'h0000_FFFF;
            FSIZE_B4: w_fmask = 32'hFFFF_FFFF;
            default:  w_fmask = '0;
        endcase
    end

    // pipeline storage: stage 0 after extraction, stages 1..DIV_STG remainder
    logic              r_vld  [0:DIV_STG];
    t_word             r_word [0:DIV_STG];
    logic [LANES-1:0]  r_sel  [0:DIV_STG];
    t_word             r_sum  [0:DIV_STG][LANES];
    t_word             r_rem  [0:DIV_STG][LANES];

    // stage 0: pick selected lanes and form old+a
    logic [LANES-1:0] n_sel;
    t_word            n_sum [LANES];
    logic [5:0]       w_fidx [LANES];
    logic [MASK_W-1:0] w_emask;

    assign w_emask = r_mask & FIELD_EN;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n_sum[j]  = ((i_req.word_value >> (8 * j)) & w_fmask) + r_opa;
            w_fidx[j] = '0;
            n_sel[j]  = 1'b0;
            case (r_fsize)
                FSIZE_B1: begin
                    w_fidx[j] = {i_req.word_index, 2'(j)};
                    n_sel[j]  = (w_fidx[j][5:4] == 2'd0) && w_emask[w_fidx[j][3:0]];
                end
                FSIZE_B2: begin
                    w_fidx[j] = {1'b0, i_req.word_index, 1'(j / 2)};
                    n_sel[j]  = (j % 2 == 0) && (w_fidx[j][5:4] == 2'd0)
                                && w_emask[w_fidx[j][3:0]];
                end
                FSIZE_B4: begin
                    w_fidx[j] = {2'd0, i_req.word_index};
                    n_sel[j]  = (j == 0) && w_emask[w_fidx[j][3:0]];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_word[0] <= i_req.word_value;
            r_sel[0]  <= n_sel;
            for (int j = 0; j < LANES; j++) begin
                r_sum[0][j] <= n_sum[j];
                r_rem[0][j] <= '0;
            end
        end
    end

    // remainder stages: shift in one sum bit, subtract b when it fits
    for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
        t_word n_rem [LANES];
        logic [WORD_W:0] w_t [LANES];

        always_comb begin
            for (int j = 0; j < LANES; j++) begin
                w_t[j] = {r_rem[k-1][j], r_sum[k-1][j][DIV_STG-k]};
                if (w_t[j] >= {1'b0, r_opb}) begin
                    n_rem[j] = WORD_W'(w_t[j] - {1'b0, r_opb});
                end else begin
                    n_rem[j] = w_t[j][WORD_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_word[k] <= r_word[k-1];
                r_sel[k]  <= r_sel[k-1];
                for (int j = 0; j < LANES; j++) begin
                    r_sum[k][j] <= r_sum[k-1][j];
                    r_rem[k][j] <= n_rem[j];
                end
            end
        end
    end

    // final stage: choose the ALU result per lane and merge into the word
    t_word n_out_word;
    logic  n_out_wr;
    t_word w_res  [LANES];
    t_word w_smsk [LANES];

    always_comb begin
        n_out_word = r_word[DIV_STG];
        for (int j = 0; j < LANES; j++) begin
            case (r_opcode)
                OP_INC_WRAP: w_res[j] = (r_opb == '0) ? r_sum[DIV_STG][j]
                                                      : r_rem[DIV_STG][j];
                OP_INC:      w_res[j] = r_sum[DIV_STG][j];
                OP_SET:      w_res[j] = r_opa;
                OP_ADD:      w_res[j] = r_apb;
                OP_MUL:      w_res[j] = r_prod;
                default:     w_res[j] = '0;
            endcase
            w_smsk[j] = w_fmask << (8 * j);
            if (r_sel[DIV_STG][j]) begin
                n_out_word = (n_out_word & ~w_smsk[j])
                           | (((w_res[j] & w_fmask) << (8 * j)) & w_smsk[j]);
            end
        end
        n_out_wr = |r_sel[DIV_STG];
    end

    t_word r_out_word;
    logic  r_out_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[DIV_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= n_out_word;
            r_out_wr   <= n_out_wr;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.new_word     = r_out_word;
    assign o_rsp.word_written = r_out_wr;

    // input is held back only while a finished result waits
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_out_vld)
        else $error("input stalled with empty output register");

    // nothing valid comes out right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("output valid right after reset");

    // the unused size code selects no field
    a_no_sel_bad_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && (r_fsize != FSIZE_B1) && (r_fsize != FSIZE_B2)
        && (r_fsize != FSIZE_B4) |-> (r_sel[0] == '0))
        else $error("field selected under unused size code");

endmodule

`default_nettype wire
